FILE: src/raster_line_of_sight_trace_unit_macros.svh
// Assertion macros shared by the line-of-sight trace unit.
`ifndef RASTER_LINE_OF_SIGHT_TRACE_UNIT_MACROS_SVH
`define RASTER_LINE_OF_SIGHT_TRACE_UNIT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define RLOS_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RLOS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: src/rlos_pkg.sv
// Types, constants and codes of the line-of-sight trace unit.
package rlos_pkg;

  localparam int COORD_W      = 24;
  localparam int DIFF_W       = 25;
  localparam int LEN_W        = 25;
  localparam int STEP_W       = 26;
  localparam int HALF_W       = 23;
  localparam int CNT_CFG_W    = 9;
  localparam int MUL_W        = 24;
  localparam int PROD_W       = 48;
  localparam int ROOT_W       = 50;
  localparam int DVD_W        = 48;
  localparam int DVS_W        = 25;
  localparam int QT_W         = 16;
  localparam int NB_W         = 5;
  localparam int FRAC_W       = 16;
  localparam int RASTER_AW    = 16;
  localparam int RASTER_DEPTH = 65536;
  localparam int CELL_W       = 8;
  localparam int CFG_AW       = 5;
  localparam int CFG_DW       = 32;
  localparam int IN_DATA_W    = 120;
  localparam int OUT_DATA_W   = 24;

  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;

  localparam logic [7:0] STEP_Q8  = 8'd251;
  localparam logic [7:0] LAND_MAX = 8'd128;
  localparam int         Q0_BITS  = 8;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Z = 3'd1,
    REG_HALF_X   = 3'd2,
    REG_HALF_Z   = 3'd3,
    REG_COLS     = 3'd4,
    REG_ROWS     = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQZ,
    ST_SQS,
    ST_ROOT,
    ST_LEN,
    ST_QXS,
    ST_QXW,
    ST_QZS,
    ST_QZW,
    ST_PT,
    ST_CXM,
    ST_CXD,
    ST_CZB,
    ST_CZM,
    ST_CZD,
    ST_ADR,
    ST_RD,
    ST_CHK,
    ST_FRW,
    ST_ADV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [NB_W-1:0]   nbits;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

endpackage

FILE: src/rlos_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rlos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: src/rlos_div.sv
// Shared restoring divider producing one quotient bit per cycle.
module rlos_div
  import rlos_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             busy,
  output logic [QT_W-1:0]  quot,
  output logic [DVD_W-1:0] rem
);

  logic             busy_r;
  logic [NB_W-1:0]  cnt_r;
  logic [DVD_W-1:0] rem_r;
  logic [DVD_W-1:0] dsh_r;
  logic [QT_W-1:0]  q_r;
  logic             fits;

  // The quotient is known to fit in nbits, so the divisor starts aligned there.
  assign fits = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == NB_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= req.nbits;
      rem_r <= req.dividend;
      dsh_r <= DVD_W'(req.divisor) << (req.nbits - NB_W'(1));
      q_r   <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[QT_W-2:0], fits};
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - NB_W'(1);
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

FILE: src/raster_line_of_sight_trace_unit.sv
// Top level of the raster line-of-sight trace unit.
//
//  Channel  | Direction | Handshake              | Contents
//  in_*     | slave     | in_tvalid / in_tready  | tuser: op; tdata: write or query fields
//  out_*    | master    | out_tvalid / out_tready| tdata: blocked, hit_fraction
//  cfg_*    | APB slave | psel/penable/pready    | six box and raster registers
//
// A raster write is accepted while idle and the unit stays ready.
// A query first takes two squares, a 25-step square root and two 8-bit quotients,
// then computes each sample in turn; a hit also takes a quotient for the fraction.
// The shared divider gives the column and row of each sample. Reset clears control
// state only; the raster needs no clearing.
// A finished result waits in the output register while the next write is taken.
`include "raster_line_of_sight_trace_unit_macros.svh"

module raster_line_of_sight_trace_unit
  import rlos_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: cell_index, cell_value, start_x, start_z, end_x, end_z.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: op.
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: blocked, hit_fraction, then zero fill.
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  // Width of a clamped column or row count and of a cell index along each axis.
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [COORD_W-1:0] ctr_x_r, ctr_z_r;
  logic [HALF_W-1:0]         half_x_r, half_z_r;
  logic [CNT_CFG_W-1:0]      cols_cfg_r, rows_cfg_r;

  // Query registers.
  logic signed [COORD_W-1:0] sx_r, sz_r;
  logic signed [DIFF_W-1:0]  dx_r, dz_r;
  logic [PROD_W-1:0]         mul_r, acc_r;
  logic [ROOT_W-1:0]         sq_n_r, sq_res_r, sq_bit_r;
  logic [LEN_W-1:0]          len_r;
  logic [Q0_BITS-1:0]        q0x_r, q0z_r;
  logic [LEN_W-1:0]          r0x_r, r0z_r, rx_r, rz_r, qx_r, qz_r;
  logic [STEP_W-1:0]         f_r;
  logic [CW-1:0]             cx_r;
  logic [RW-1:0]             cz_r;
  logic                      hit_r;
  logic [FRAC_W-1:0]         frac_r;
  logic                      out_valid_r;
  logic [FRAC_W:0]           out_data_r;

  logic                 in_acc, cfg_wr, out_load;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [DIFF_W-1:0]    adx_w, adz_w;
  logic [MUL_W-1:0]     adx, adz;
  logic [ROOT_W-1:0]    sq_trial;
  logic                 sq_take;
  logic [CW-1:0]        cols_lim;
  logic [RW-1:0]        rows_lim;
  logic signed [DIFF_W-1:0] lo_x, hi_x, lo_z, hi_z;
  logic [MUL_W-1:0]     span_x, span_z;
  logic signed [STEP_W-1:0] px, pz, offx_w, offz_w;
  logic                 in_x, in_z;
  logic [STEP_W-1:0]    f_nxt;
  logic [LEN_W:0]       rx_sum, rz_sum;
  logic                 wrap_x, wrap_z;
  logic                 ram_re, land;
  logic [RASTER_AW-1:0] raddr;
  logic [CELL_W-1:0]    rdata;
  logic [PROD_W-1:0]    addr_sum;
  div_req_t             div_req;
  logic                 div_busy;
  logic [QT_W-1:0]      div_quot;
  logic [DVD_W-1:0]     div_rem;

  assign in_tready = state_r == ST_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Configuration writes and read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_x_r    <= '0;
      ctr_z_r    <= '0;
      half_x_r   <= HALF_W'(256);
      half_z_r   <= HALF_W'(256);
      cols_cfg_r <= CNT_CFG_W'(256);
      rows_cfg_r <= CNT_CFG_W'(256);
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[4:2]))
        REG_CENTER_X: ctr_x_r    <= cfg_pwdata[COORD_W-1:0];
        REG_CENTER_Z: ctr_z_r    <= cfg_pwdata[COORD_W-1:0];
        REG_HALF_X:   half_x_r   <= cfg_pwdata[HALF_W-1:0];
        REG_HALF_Z:   half_z_r   <= cfg_pwdata[HALF_W-1:0];
        REG_COLS:     cols_cfg_r <= cfg_pwdata[CNT_CFG_W-1:0];
        REG_ROWS:     rows_cfg_r <= cfg_pwdata[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_CENTER_X: cfg_prdata = CFG_DW'(ctr_x_r);
      REG_CENTER_Z: cfg_prdata = CFG_DW'(ctr_z_r);
      REG_HALF_X:   cfg_prdata = CFG_DW'(half_x_r);
      REG_HALF_Z:   cfg_prdata = CFG_DW'(half_z_r);
      REG_COLS:     cfg_prdata = CFG_DW'(cols_cfg_r);
      REG_ROWS:     cfg_prdata = CFG_DW'(rows_cfg_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Counts in use: zero reads as one, and a count above the maximum saturates.
  always_comb begin
    if (cols_cfg_r == '0) begin
      cols_lim = CW'(1);
    end else if (32'(cols_cfg_r) > 32'(MAX_COLS)) begin
      cols_lim = CW'(MAX_COLS);
    end else begin
      cols_lim = CW'(cols_cfg_r);
    end
    if (rows_cfg_r == '0) begin
      rows_lim = RW'(1);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      rows_lim = RW'(MAX_ROWS);
    end else begin
      rows_lim = RW'(rows_cfg_r);
    end
  end

  // Box edges are exact in 25 bits; the span is twice the half size.
  assign lo_x   = DIFF_W'(ctr_x_r) - $signed({2'b00, half_x_r});
  assign hi_x   = DIFF_W'(ctr_x_r) + $signed({2'b00, half_x_r});
  assign lo_z   = DIFF_W'(ctr_z_r) - $signed({2'b00, half_z_r});
  assign hi_z   = DIFF_W'(ctr_z_r) + $signed({2'b00, half_z_r});
  assign span_x = {half_x_r, 1'b0};
  assign span_z = {half_z_r, 1'b0};

  assign adx_w = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
  assign adz_w = dz_r[DIFF_W-1] ? DIFF_W'(-dz_r) : DIFF_W'(dz_r);
  assign adx   = adx_w[MUL_W-1:0];
  assign adz   = adz_w[MUL_W-1:0];

  // Sample point: the offset along each axis is the truncated quotient with the
  // sign of the difference, kept incrementally as quotient and remainder.
  assign px = STEP_W'(sx_r) +
              (dx_r[DIFF_W-1] ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r}));
  assign pz = STEP_W'(sz_r) +
              (dz_r[DIFF_W-1] ? -$signed({1'b0, qz_r}) : $signed({1'b0, qz_r}));
  assign in_x   = (px >= STEP_W'(lo_x)) && (px <= STEP_W'(hi_x));
  assign in_z   = (pz >= STEP_W'(lo_z)) && (pz <= STEP_W'(hi_z));
  assign offx_w = px - STEP_W'(lo_x);
  assign offz_w = pz - STEP_W'(lo_z);

  assign f_nxt  = f_r + STEP_W'(STEP_Q8);
  assign rx_sum = {1'b0, rx_r} + {1'b0, r0x_r};
  assign rz_sum = {1'b0, rz_r} + {1'b0, r0z_r};
  assign wrap_x = rx_sum >= {1'b0, len_r};
  assign wrap_z = rz_sum >= {1'b0, len_r};

  assign sq_trial = sq_res_r + sq_bit_r;
  assign sq_take  = sq_n_r >= sq_trial;

  assign addr_sum = mul_r + PROD_W'(cx_r);
  assign raddr    = addr_sum[RASTER_AW-1:0];
  assign land     = rdata <= LAND_MAX;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && in_tuser) state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQZ;
      ST_SQZ:  state_nxt = ST_SQS;
      ST_SQS:  state_nxt = ST_ROOT;
      ST_ROOT: if (sq_bit_r == ROOT_W'(1)) state_nxt = ST_LEN;
      ST_LEN:  state_nxt = (sq_res_r == '0) ? ST_DONE : ST_QXS;
      ST_QXS:  state_nxt = ST_QXW;
      ST_QXW:  if (!div_busy) state_nxt = ST_QZS;
      ST_QZS:  state_nxt = ST_QZW;
      ST_QZW:  if (!div_busy) state_nxt = ST_PT;
      ST_PT:   state_nxt = in_x ? ST_CXM : ST_ADV;
      ST_CXM:  state_nxt = (span_x == '0) ? ST_CZB : ST_CXD;
      ST_CXD:  if (!div_busy) state_nxt = ST_CZB;
      ST_CZB:  state_nxt = in_z ? ST_CZM : ST_ADV;
      ST_CZM:  state_nxt = (span_z == '0) ? ST_ADR : ST_CZD;
      ST_CZD:  if (!div_busy) state_nxt = ST_ADR;
      ST_ADR:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_CHK;
      ST_CHK:  state_nxt = land ? ST_FRW : ST_ADV;
      ST_FRW:  if (!div_busy) state_nxt = ST_DONE;
      ST_ADV:  state_nxt = (f_nxt >= STEP_W'(len_r)) ? ST_DONE : ST_PT;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Operands of the shared multiplier, divider requests and the raster read.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    ram_re  = 1'b0;
    case (state_r)
      ST_SQX: begin
        mul_a = adx;
        mul_b = adx;
      end
      ST_SQZ: begin
        mul_a = adz;
        mul_b = adz;
      end
      ST_LEN: begin
        mul_a = adx;
        mul_b = MUL_W'(STEP_Q8);
      end
      ST_QXS, ST_QXW, ST_QZS: begin
        mul_a = adz;
        mul_b = MUL_W'(STEP_Q8);
        if (state_r == ST_QXS || state_r == ST_QZS) begin
          div_req.start    = 1'b1;
          div_req.nbits    = NB_W'(Q0_BITS);
          div_req.dividend = mul_r;
          div_req.divisor  = len_r;
        end
      end
      ST_PT: begin
        mul_a = MUL_W'(cols_lim);
        mul_b = offx_w[MUL_W-1:0];
      end
      ST_CXM: begin
        if (span_x != '0) begin
          div_req.start    = 1'b1;
          div_req.nbits    = NB_W'(CW);
          div_req.dividend = mul_r;
          div_req.divisor  = DVS_W'(span_x);
        end
      end
      ST_CZB: begin
        mul_a = MUL_W'(rows_lim);
        mul_b = offz_w[MUL_W-1:0];
      end
      ST_CZM: begin
        if (span_z != '0) begin
          div_req.start    = 1'b1;
          div_req.nbits    = NB_W'(RW);
          div_req.dividend = mul_r;
          div_req.divisor  = DVS_W'(span_z);
        end
      end
      ST_ADR: begin
        mul_a = MUL_W'(cz_r);
        mul_b = MUL_W'(cols_lim);
      end
      ST_RD: ram_re = 1'b1;
      ST_CHK: begin
        if (land) begin
          div_req.start    = 1'b1;
          div_req.nbits    = NB_W'(FRAC_W);
          div_req.dividend = DVD_W'({f_r, 16'h0000});
          div_req.divisor  = len_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        sx_r   <= in_tdata[47:24];
        sz_r   <= in_tdata[71:48];
        dx_r   <= DIFF_W'($signed(in_tdata[95:72])) - DIFF_W'($signed(in_tdata[47:24]));
        dz_r   <= DIFF_W'($signed(in_tdata[119:96])) - DIFF_W'($signed(in_tdata[71:48]));
        hit_r  <= 1'b0;
        frac_r <= '0;
      end
      ST_SQZ: acc_r <= mul_r;
      ST_SQS: begin
        sq_n_r   <= ROOT_W'(acc_r) + ROOT_W'(mul_r);
        sq_res_r <= '0;
        sq_bit_r <= ROOT_W'(1) << (ROOT_W - 2);
      end
      ST_ROOT: begin
        if (sq_take) begin
          sq_n_r   <= sq_n_r - sq_trial;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      ST_LEN: len_r <= sq_res_r[LEN_W-1:0];
      ST_QXW: begin
        q0x_r <= div_quot[Q0_BITS-1:0];
        r0x_r <= div_rem[LEN_W-1:0];
      end
      ST_QZW: begin
        q0z_r <= div_quot[Q0_BITS-1:0];
        r0z_r <= div_rem[LEN_W-1:0];
        qx_r  <= '0;
        qz_r  <= '0;
        rx_r  <= '0;
        rz_r  <= '0;
        f_r   <= '0;
      end
      ST_CXM: cx_r <= '0;
      ST_CXD: cx_r <= (div_quot >= QT_W'(cols_lim)) ? cols_lim - CW'(1) : div_quot[CW-1:0];
      ST_CZM: cz_r <= '0;
      ST_CZD: cz_r <= (div_quot >= QT_W'(rows_lim)) ? rows_lim - RW'(1) : div_quot[RW-1:0];
      ST_FRW: begin
        hit_r  <= 1'b1;
        frac_r <= div_quot;
      end
      ST_ADV: begin
        f_r  <= f_nxt;
        rx_r <= wrap_x ? LEN_W'(rx_sum - {1'b0, len_r}) : rx_sum[LEN_W-1:0];
        rz_r <= wrap_z ? LEN_W'(rz_sum - {1'b0, len_r}) : rz_sum[LEN_W-1:0];
        qx_r <= qx_r + LEN_W'(q0x_r) + LEN_W'(wrap_x);
        qz_r <= qz_r + LEN_W'(q0z_r) + LEN_W'(wrap_z);
      end
      default: ;
    endcase
  end

  // Output register: the result is held until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {frac_r, hit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

  rlos_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  rlos_ram #(
    .WIDTH (CELL_W),
    .DEPTH (RASTER_DEPTH)
  ) u_raster (
    .clk   (clk),
    .we    (in_acc && !in_tuser),
    .waddr (in_tdata[15:0]),
    .wdata (in_tdata[23:16]),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  `RLOS_ASSERT_IMPLIES(a_chk_follows_read, state_r == ST_CHK, $past(state_r) == ST_RD, "raster data checked without a read")
  `RLOS_ASSERT_IMPLIES(a_div_free, div_req.start, !div_busy, "divider started while busy")
  `RLOS_ASSERT_IMPLIES(a_rem_bound, state_r == ST_PT, (rx_r < len_r) && (rz_r < len_r), "step remainder not below length")
  `RLOS_ASSERT_IMPLIES(a_step_in_len, state_r == ST_PT, f_r < STEP_W'(len_r), "sample beyond segment length")

endmodule
